>>> rtl/box_overlap_index_search_core_macros.svh
// ----------------------------------------------------------------------------
// Box overlap index search - assertion macros
// Concurrent check wrappers used by the top-level RTL file; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOX_OVERLAP_INDEX_SEARCH_CORE_MACROS_SVH
`define BOX_OVERLAP_INDEX_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
// checked on clk, suspended while rst_n is low
`define BOX_OVL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("box_ovl assertion failed");
// checked on clk, also during reset
`define BOX_OVL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("box_ovl assertion failed");
`else
`define BOX_OVL_ASSERT(lbl, prop)
`define BOX_OVL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/box_ovl_pkg.sv
// ----------------------------------------------------------------------------
// Box overlap index search - package
// Shared widths, codes and types of the box overlap search core.
// ----------------------------------------------------------------------------
package box_ovl_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_MAX_DIMS    = 3;
  localparam int NDIM            = 3;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_DATA_W       = 240;
  localparam int IN_USER_W       = 3;
  localparam int OUT_DATA_W      = 384;

  localparam logic [47:0] OFF_MAX = 48'hFFFF_FFFF_FFFF;

  // register indexes on the configuration channel
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_DIMS      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ELEMENT_BYTES = 2'd1;

  // input item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FLUSH} state_t;
  typedef enum logic [1:0] {V_IDLE, V_LO, V_HI, V_ADD} vstate_t;

  // one stored box
  typedef struct packed {
    logic [NDIM-1:0][31:0] start;
    logic [NDIM-1:0][31:0] ext;
    logic [47:0]           foff;
  } entry_t;

  // overlap test outcome for one stored box
  typedef struct packed {
    logic                  hit;
    logic [NDIM-1:0][31:0] frel;
    logic [NDIM-1:0][31:0] mrel;
    logic [NDIM-1:0][31:0] ov;
  } match_t;

  // one result item
  typedef struct packed {
    logic [NDIM-1:0][31:0] frel;
    logic [NDIM-1:0][31:0] mrel;
    logic [NDIM-1:0][31:0] ov;
    logic [47:0]           foff;
    logic [47:0]           moff;
    logic                  last;
  } result_t;

endpackage

>>> rtl/box_ovl_cell.sv
// ----------------------------------------------------------------------------
// Box overlap index search - table cell
// Holds one stored box; rotates to its neighbor during a table walk.
// ----------------------------------------------------------------------------
module box_ovl_cell
  import box_ovl_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             shift,
  input  logic             load_we,
  input  logic [CNT_W-1:0] load_idx,
  input  entry_t           load_data,
  input  entry_t           prev_data,
  output entry_t           data
);

  entry_t data_r;

  // rotate during a walk, take a new box when this slot is next free
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= prev_data;
    end else if (load_we && (load_idx == CNT_W'(INDEX))) begin
      data_r <= load_data;
    end
  end

  assign data = data_r;

endmodule

>>> rtl/box_ovl_match.sv
// ----------------------------------------------------------------------------
// Box overlap index search - overlap test
// Per-dimension intersection of the head box with the query box.
// ----------------------------------------------------------------------------
module box_ovl_match
  import box_ovl_pkg::*;
(
  input  entry_t                entry,
  input  logic [NDIM-1:0][31:0] q_start,
  input  logic [NDIM-1:0][31:0] q_ext,
  input  logic [1:0]            nd,
  output match_t                m
);

  always_comb begin
    logic [32:0] sa, ea, sb, eb, so, eo;
    logic [32:0] dov, dfr, dmr;
    m = '0;
    m.hit = 1'b1;
    for (int d = 0; d < NDIM; d++) begin
      // ends formed at 33 bits so nothing wraps
      sa  = {1'b0, entry.start[d]};
      ea  = sa + {1'b0, entry.ext[d]};
      sb  = {1'b0, q_start[d]};
      eb  = sb + {1'b0, q_ext[d]};
      so  = (sa > sb) ? sa : sb;
      eo  = (ea < eb) ? ea : eb;
      dov = eo - so;
      dfr = so - sa;
      dmr = so - sb;
      if (2'(d) < nd) begin
        if (eo <= so) begin
          m.hit = 1'b0;
        end
        m.ov[d]   = dov[31:0];
        m.frel[d] = dfr[31:0];
        m.mrel[d] = dmr[31:0];
      end
    end
  end

endmodule

>>> rtl/box_ovl_vol.sv
// ----------------------------------------------------------------------------
// Box overlap index search - volume unit
// Saturating element_bytes times query volume, built up over the active dimensions in low, high and add steps.
// ----------------------------------------------------------------------------
module box_ovl_vol
  import box_ovl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [15:0]           elem_bytes,
  input  logic [NDIM-1:0][31:0] ext,
  input  logic [1:0]            nd,
  output logic                  done,
  output logic [47:0]           vol
);

  vstate_t     state_r, state_nxt;
  logic [1:0]  d_r, d_nxt;
  logic [47:0] acc_r, acc_nxt;
  logic [63:0] lo_r;
  logic [47:0] hi_r;
  logic [79:0] sum;

  // partial products of the 48-bit accumulator times one 32-bit extent
  always_ff @(posedge clk) begin
    if (state_r == V_LO) begin
      lo_r <= acc_r[31:0] * ext[d_r];
    end
    if (state_r == V_HI) begin
      hi_r <= acc_r[47:32] * ext[d_r];
    end
  end

  assign sum = {hi_r, 32'd0} + {16'd0, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      d_r     <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // step sequencer over the active dimensions
  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    case (state_r)
      V_IDLE: begin
        if (start) begin
          acc_nxt   = {32'd0, elem_bytes};
          d_nxt     = '0;
          state_nxt = V_LO;
        end
      end
      V_LO:  state_nxt = V_HI;
      V_HI:  state_nxt = V_ADD;
      V_ADD: begin
        acc_nxt   = (sum[79:48] != '0) ? OFF_MAX : sum[47:0];
        d_nxt     = d_r + 2'd1;
        state_nxt = ((d_r + 2'd1) >= nd) ? V_IDLE : V_LO;
      end
      default: state_nxt = V_IDLE;
    endcase
  end

  assign done = (state_r == V_IDLE);
  assign vol  = acc_r;

endmodule

>>> rtl/box_overlap_index_search_core.sv
// ----------------------------------------------------------------------------
// Box overlap index search - top level
// Stored box table as a ring of cells, walked once per query.
// ----------------------------------------------------------------------------
// Input channel in_*: kind in in_tuser selects load, query or clear. A load
// appends a box to the table (ignored when full), a clear empties it. A
// query rotates the cell ring one full turn, testing the box at the head
// cell against the query at each shift; the walk length is set by the ring
// size, not by how many boxes are stored. A query ends once the walk and the
// volume unit (three steps per dimension) are done and any held result has
// reached the output register. One item is in work at a time; in_tready is
// low meanwhile.
// Results leave on out_* through an output register; a hit is held one step
// so the final result of a query carries out_tlast. If out_tready is low
// while a new hit needs the output, the walk pauses and no result is lost.
// Queries with no overlap emit nothing but still advance the memory offset.
// cfg_* writes num_dims (index 0) and element_bytes (index 1); always ready.
// Reset (rst_n low, synchronous) empties the table, zeroes the memory offset
// and sets num_dims 3, element_bytes 1.
// ----------------------------------------------------------------------------
`include "box_overlap_index_search_core_macros.svh"

module box_overlap_index_search_core
  import box_ovl_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_DIMS    = DEF_MAX_DIMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: coord0, coord1, coord2, extent0, extent1, extent2, file_offset
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: kind[1:0], first_query
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: file_rel0..2, mem_rel0..2, overlap0..2, hit_file_offset,
  //        hit_mem_offset
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [1:0] DIMS_TOP = 2'(MAX_DIMS);

  // configuration registers
  logic [1:0]  num_dims_r;
  logic [15:0] elem_bytes_r;

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [47:0]         run_r, run_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic                out_v_r, out_v_nxt;
  result_t             pend_r, pend_nxt;
  result_t             out_r, out_nxt;

  // query box
  logic [NDIM-1:0][31:0] q_start_r, q_ext_r;
  logic [1:0]            nd_r;
  logic                  q_we;

  logic        shift, load_we, vol_start, vol_done;
  logic [47:0] vol;
  logic [48:0] run_sum;
  logic [1:0]  kind;
  logic        cur_ok, hit_now, adv, out_free;
  logic [1:0]  nd_in;
  entry_t      load_data;
  entry_t      cell_q [MAX_ENTRIES];
  match_t      m;

  assign kind = in_tuser[1:0];

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r   <= 2'd3;
      elem_bytes_r <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_NUM_DIMS:      num_dims_r   <= cfg_data[1:0];
        REG_ELEMENT_BYTES: elem_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // active dimension count, clamped to 1..MAX_DIMS
  always_comb begin
    nd_in = num_dims_r;
    if (nd_in == 2'd0) begin
      nd_in = 2'd1;
    end
    if (nd_in > DIMS_TOP) begin
      nd_in = DIMS_TOP;
    end
  end

  // box carried by a load
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      load_data.start[d] = in_tdata[32*d +: 32];
      load_data.ext[d]   = in_tdata[96 + 32*d +: 32];
    end
    load_data.foff = in_tdata[239:192];
  end

  // ring of table cells; the head cell feeds the overlap test
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    box_ovl_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .shift     (shift),
      .load_we   (load_we),
      .load_idx  (used_r),
      .load_data (load_data),
      .prev_data (cell_q[(i + 1) % MAX_ENTRIES]),
      .data      (cell_q[i])
    );
  end

  box_ovl_match u_match (
    .entry   (cell_q[0]),
    .q_start (q_start_r),
    .q_ext   (q_ext_r),
    .nd      (nd_r),
    .m       (m)
  );

  box_ovl_vol u_vol (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (vol_start),
    .elem_bytes (elem_bytes_r),
    .ext        (q_ext_r),
    .nd         (nd_r),
    .done       (vol_done),
    .vol        (vol)
  );

  // query capture
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_start_r <= load_data.start;
      q_ext_r   <= load_data.ext;
      nd_r      <= nd_in;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_v_r || out_tready;
  assign cur_ok    = (step_r < used_r);
  assign hit_now   = cur_ok && m.hit;
  assign adv       = !hit_now || !pend_v_r || out_free;
  assign run_sum   = {1'b0, run_r} + {1'b0, vol};

  // next state
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    used_nxt   = used_r;
    run_nxt    = run_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && !out_tready;
    shift      = 1'b0;
    load_we    = 1'b0;
    vol_start  = 1'b0;
    q_we       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (kind)
            KIND_LOAD: begin
              if (used_r < CNT_W'(MAX_ENTRIES)) begin
                load_we  = 1'b1;
                used_nxt = used_r + 1'b1;
              end
            end
            KIND_QUERY: begin
              q_we      = 1'b1;
              vol_start = 1'b1;
              step_nxt  = '0;
              if (in_tuser[2]) begin
                run_nxt = '0;
              end
              state_nxt = S_WALK;
            end
            KIND_CLEAR: used_nxt = '0;
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (adv) begin
          shift    = 1'b1;
          step_nxt = step_r + 1'b1;
          if (hit_now) begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_nxt.frel = m.frel;
            pend_nxt.mrel = m.mrel;
            pend_nxt.ov   = m.ov;
            pend_nxt.foff = cell_q[0].foff;
            pend_nxt.moff = run_r;
            pend_nxt.last = 1'b1;
            pend_v_nxt    = 1'b1;
          end
          if (step_r == CNT_W'(MAX_ENTRIES - 1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if ((!pend_v_r || out_free) && vol_done) begin
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
            out_v_nxt    = 1'b1;
            pend_v_nxt   = 1'b0;
          end
          run_nxt   = run_sum[48] ? OFF_MAX : run_sum[47:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      used_r   <= '0;
      run_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      used_r   <= used_nxt;
      run_r    <= run_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // result channel
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.moff, out_r.foff,
                       out_r.ov[2], out_r.ov[1], out_r.ov[0],
                       out_r.mrel[2], out_r.mrel[1], out_r.mrel[0],
                       out_r.frel[2], out_r.frel[1], out_r.frel[0]};

  // checks
  `BOX_OVL_ASSERT(a_idle_drained, state_r == S_IDLE |-> !pend_v_r)
  `BOX_OVL_ASSERT(a_used_bound, used_r <= CNT_W'(MAX_ENTRIES))
  `BOX_OVL_ASSERT(a_query_walks, in_tvalid && in_tready && kind == KIND_QUERY |=> state_r == S_WALK)
  `BOX_OVL_ASSERT(a_walk_no_load, state_r != S_IDLE |-> !load_we)

endmodule

>>> tb/box_overlap_index_search_core_tb.sv
// ----------------------------------------------------------------------------
// Box overlap index search - testbench
// Streams load, query and clear transfers into the core under several
// num_dims / element_bytes settings, predicts every overlap result in an
// in-bench table model and checks each output transfer field by field.
// ----------------------------------------------------------------------------
module box_overlap_index_search_core_tb;
  import box_ovl_pkg::*;

  localparam int TBL_DEPTH = DEF_MAX_ENTRIES;
  localparam int SETTLE    = 200;   // idle cycles covering one full table walk
  localparam int PHASE_ITEMS = 72;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_e;

  // one queued stimulus step: a box transfer, a register write or a drain point
  typedef struct packed {
    op_e                   op;
    logic [1:0]            kind;
    logic [2:0][31:0]      st;
    logic [2:0][31:0]      ex;
    logic [47:0]           foff;
    logic                  first;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] val;
  } step_t;

  // one expected overlap result
  typedef struct packed {
    logic [2:0][31:0] frel;
    logic [2:0][31:0] mrel;
    logic [2:0][31:0] ov;
    logic [47:0]      foff;
    logic [47:0]      moff;
    logic             last;
  } hit_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  step_t pend_q[$];
  hit_t  hit_q[$];
  step_t cur_step;

  // predictor state
  logic [2:0][31:0] tbl_st [TBL_DEPTH];
  logic [2:0][31:0] tbl_ex [TBL_DEPTH];
  logic [47:0]      tbl_off[TBL_DEPTH];
  int unsigned      tbl_used;
  logic [47:0]      mem_off;
  logic [1:0]       dims_reg;
  logic [15:0]      ebytes_reg;

  int errors, n_queries, n_hits, n_loads, n_cfg;
  int gap_cnt, burst_cnt, quiet_cnt;
  int stall_mode, mode_cnt, stall_cnt;
  bit drain_ok;
  bit nv, ncv;

  box_overlap_index_search_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic logic [47:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
    if (a == 0 || b == 0) return 48'd0;
    if (a > {16'd0, OFF_MAX} / b) return OFF_MAX;
    return 48'(a * b);
  endfunction

  // table model: update on an accepted transfer, queue expected hits
  task automatic predict_transfer(input step_t s);
    int unsigned nd;
    logic [63:0] vol, sum;
    logic [32:0] sa, ea, sb, eb, so, eo;
    hit_t h;
    bit hit;
    int cnt;
    cnt = 0;
    case (s.kind)
      KIND_LOAD: begin
        if (tbl_used < TBL_DEPTH) begin
          tbl_st[tbl_used]  = s.st;
          tbl_ex[tbl_used]  = s.ex;
          tbl_off[tbl_used] = s.foff;
          tbl_used++;
        end
        n_loads++;
      end
      KIND_CLEAR: tbl_used = 0;
      KIND_QUERY: begin
        n_queries++;
        if (s.first) mem_off = '0;
        nd = (dims_reg == 0) ? 1 : (dims_reg > DEF_MAX_DIMS ? DEF_MAX_DIMS : dims_reg);
        vol = 64'(ebytes_reg);
        for (int d = 0; d < nd; d++) vol = 64'(sat_mul(vol, 64'(s.ex[d])));
        for (int e = 0; e < tbl_used; e++) begin
          h = '0;
          hit = 1;
          for (int d = 0; d < nd; d++) begin
            sa = {1'b0, tbl_st[e][d]}; ea = sa + {1'b0, tbl_ex[e][d]};
            sb = {1'b0, s.st[d]};      eb = sb + {1'b0, s.ex[d]};
            so = (sa > sb) ? sa : sb;
            eo = (ea < eb) ? ea : eb;
            if (eo <= so) begin
              hit = 0;
              break;
            end
            h.ov[d]   = 32'(eo - so);
            h.frel[d] = 32'(so - sa);
            h.mrel[d] = 32'(so - sb);
          end
          if (hit) begin
            h.foff = tbl_off[e];
            h.moff = mem_off;
            hit_q.insert(hit_q.size(), h);
            cnt++;
          end
        end
        if (cnt > 0) hit_q[hit_q.size()-1].last = 1'b1;
        sum = {16'd0, mem_off} + vol;
        mem_off = (sum > {16'd0, OFF_MAX}) ? OFF_MAX : sum[47:0];
      end
      default: ;  // unused kind: no effect
    endcase
  endtask

  // driver: bursts of transfers with random gaps; register writes and drain
  // points wait until the core has gone quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      cfg_addr  <= '0;
      cfg_data  <= '0;
      gap_cnt   <= 0;
      burst_cnt <= 1;
      quiet_cnt <= 0;
      tbl_used   = 0;
      mem_off    = '0;
      dims_reg   = 2'd3;
      ebytes_reg = 16'd1;
    end else begin
      if (in_tvalid && in_tready) predict_transfer(cur_step);
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_NUM_DIMS) dims_reg = cfg_data[1:0];
        else if (cfg_addr == REG_ELEMENT_BYTES) ebytes_reg = cfg_data;
        n_cfg++;
      end
      quiet_cnt <= (in_tvalid || cfg_valid || hit_q.size() != 0) ? 0 : quiet_cnt + 1;
      nv  = in_tvalid && !in_tready;
      ncv = cfg_valid && !cfg_ready;
      if (!nv && !ncv) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pend_q.size() != 0) begin
          drain_ok = (quiet_cnt >= SETTLE) && !in_tvalid && !cfg_valid;
          case (pend_q[0].op)
            OP_ITEM: begin
              cur_step <= pend_q[0];
              in_tdata <= {pend_q[0].foff, pend_q[0].ex, pend_q[0].st};
              in_tuser <= {pend_q[0].first, pend_q[0].kind};
              nv = 1;
              void'(pend_q.pop_front());
              if (burst_cnt <= 1) begin
                burst_cnt <= $urandom_range(1, 12);
                gap_cnt   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
              end else begin
                burst_cnt <= burst_cnt - 1;
              end
            end
            OP_CFG: if (drain_ok) begin
              cfg_addr <= pend_q[0].addr;
              cfg_data <= pend_q[0].val;
              ncv = 1;
              void'(pend_q.pop_front());
            end
            default: if (drain_ok) void'(pend_q.pop_front());
          endcase
        end
      end
      in_tvalid <= nv;
      cfg_valid <= ncv;
    end
  end

  // receiver: stall pattern switches at random between four modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode <= 0;
      mode_cnt   <= 0;
      stall_cnt  <= 0;
    end else begin
      if (mode_cnt == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_cnt   <= $urandom_range(50, 400);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_cnt > 0) begin
            stall_cnt  <= stall_cnt - 1;
            out_tready <= 1'b0;
          end else begin
            stall_cnt  <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // monitor: compare each output transfer with the oldest expected hit
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (hit_q.size() == 0) begin
        report("unexpected result transfer", out_tdata[63:0], 64'd0);
      end else begin
        for (int d = 0; d < 3; d++) begin
          if (out_tdata[32*d +: 32] !== hit_q[0].frel[d])
            report($sformatf("file_rel%0d", d), 64'(out_tdata[32*d +: 32]),
                   64'(hit_q[0].frel[d]));
          if (out_tdata[96+32*d +: 32] !== hit_q[0].mrel[d])
            report($sformatf("mem_rel%0d", d), 64'(out_tdata[96+32*d +: 32]),
                   64'(hit_q[0].mrel[d]));
          if (out_tdata[192+32*d +: 32] !== hit_q[0].ov[d])
            report($sformatf("overlap%0d", d), 64'(out_tdata[192+32*d +: 32]),
                   64'(hit_q[0].ov[d]));
        end
        if (out_tdata[288 +: 48] !== hit_q[0].foff)
          report("hit_file_offset", 64'(out_tdata[288 +: 48]), 64'(hit_q[0].foff));
        if (out_tdata[336 +: 48] !== hit_q[0].moff)
          report("hit_mem_offset", 64'(out_tdata[336 +: 48]), 64'(hit_q[0].moff));
        if (out_tlast !== hit_q[0].last)
          report("last", 64'(out_tlast), 64'(hit_q[0].last));
        void'(hit_q.pop_front());
        n_hits++;
      end
    end
  end

  function automatic step_t box_step(input logic [1:0] kind, input logic [31:0] s,
                                     input logic [31:0] e, input logic [47:0] off,
                                     input logic first);
    step_t t;
    t = '0;
    t.op = OP_ITEM; t.kind = kind; t.foff = off; t.first = first;
    for (int d = 0; d < 3; d++) begin
      t.st[d] = s;
      t.ex[d] = e;
    end
    return t;
  endfunction

  // random box, mostly in a small window so boxes overlap often
  function automatic step_t rand_box(input logic [1:0] kind);
    step_t t;
    int m;
    t = '0;
    t.op = OP_ITEM; t.kind = kind;
    t.foff = 48'({$urandom, $urandom});
    t.first = ($urandom_range(0, 4) == 0);
    m = $urandom_range(0, 9);
    for (int d = 0; d < 3; d++) begin
      case (m)
        7: begin t.st[d] = $urandom; t.ex[d] = $urandom; end
        8: begin
          t.st[d] = 32'hFFFF_FFC0 + $urandom_range(0, 63);
          t.ex[d] = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 80);
        end
        9: begin
          t.st[d] = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
          t.ex[d] = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom_range(0, 2);
        end
        default: begin
          t.st[d] = $urandom_range(0, 60);
          t.ex[d] = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 40);
        end
      endcase
    end
    return t;
  endfunction

  // append one step to the stimulus queue
  task automatic enqueue(input step_t t);
    pend_q.insert(pend_q.size(), t);
  endtask

  task automatic add_cfg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] v);
    step_t t;
    t = '0;
    t.op = OP_CFG; t.addr = a; t.val = v;
    enqueue(t);
  endtask

  task automatic add_drain();
    step_t t;
    t = '0;
    t.op = OP_DRAIN;
    enqueue(t);
  endtask

  initial begin
    logic [1:0]  dims_set  [6];
    logic [15:0] bytes_set [6];
    int made, nl, nq;
    step_t t;
    dims_set  = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};
    bytes_set = '{16'hFFFF, 16'd3, 16'd7, 16'hFFFF, 16'd0, 16'd1};
    errors = 0; n_queries = 0; n_hits = 0; n_loads = 0; n_cfg = 0;
    rst_n = 1'b0;

    // directed: extremes, touching boxes, empty volume, unused kind, empty table
    enqueue(box_step(KIND_CLEAR, 0, 0, 0, 0));
    enqueue(box_step(KIND_LOAD, 0, 10, 48'd0, 0));
    enqueue(box_step(KIND_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OFF_MAX, 0));
    enqueue(box_step(KIND_LOAD, 5, 1, 48'h1234_5678_9ABC, 0));
    enqueue(box_step(KIND_QUERY, 0, 32'hFFFF_FFFF, 0, 1));
    enqueue(box_step(KIND_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 0));
    enqueue(box_step(KIND_QUERY, 10, 5, 0, 0));
    enqueue(box_step(KIND_QUERY, 3, 0, 0, 0));
    enqueue(box_step(2'd3, 1, 1, 0, 1));
    enqueue(box_step(KIND_QUERY, 3, 4, OFF_MAX, 0));
    add_drain();
    enqueue(box_step(KIND_QUERY, 32'hFFFF_FFFF, 1, 0, 1));
    enqueue(box_step(KIND_CLEAR, 0, 0, 0, 0));
    enqueue(box_step(KIND_QUERY, 0, 32'hFFFF_FFFF, 0, 0));

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      add_cfg(REG_NUM_DIMS, {14'd0, dims_set[p]});
      add_cfg(REG_ELEMENT_BYTES, bytes_set[p]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          enqueue(box_step(KIND_CLEAR, $urandom, $urandom, 0, 0));
          nl = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 66) : $urandom_range(1, 10);
          for (int i = 0; i < nl; i++) enqueue(rand_box(KIND_LOAD));
          nq = $urandom_range(1, 4);
          for (int i = nq; i > 0; i--) enqueue(rand_box(KIND_QUERY));
          made += nl + nq + 1;
        end else begin
          t = rand_box(2'($urandom_range(0, 3)));
          enqueue(t);
          made++;
        end
      end
      if (p == 2) add_drain();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pend_q.size() == 0);
    @(posedge clk);
    while (in_tvalid || cfg_valid || hit_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (hit_q.size() != 0) begin
      $display("%0d expected results never arrived", hit_q.size());
      errors++;
    end
    $display("covered %0d loads, %0d queries, %0d register writes", n_loads, n_queries, n_cfg);
    $display("checked %0d overlap results, %0d mismatches", n_hits, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
